// ----- design/ssum_pkg.sv -----
`timescale 1ns / 1ps

package ssum_pkg;

   localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
   localparam logic [1:0] KIND_MERGE       = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] merged_value;
      logic               last;
      logic               dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic emit_drop;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic first_full;
      logic second_full;
      logic both_empty;
      logic step_last;
      logic out_free;
   } status_type;

endpackage

// ----- design/ssum_ctrl.sv -----
`timescale 1ns / 1ps

module ssum_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  ssum_pkg::status_type status,
   output ssum_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || !status.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  ssum_pkg::KIND_LOAD_FIRST: begin
                     cmd.wr_first  = !status.first_full;
                     cmd.emit_drop = status.first_full;
                  end
                  ssum_pkg::KIND_LOAD_SECOND: begin
                     cmd.wr_second = !status.second_full;
                     cmd.emit_drop = status.second_full;
                  end
                  ssum_pkg::KIND_MERGE: begin
                     if (!status.both_empty) begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            cmd.step = status.out_free;
            if (status.out_free && status.step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ssum_datapath.sv -----
`timescale 1ns / 1ps

module ssum_datapath #(
   parameter int DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   load_value,
   input  ssum_pkg::cmd_type    cmd,
   output ssum_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssum_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic signed [31:0] first_mem [DEPTH];
   logic signed [31:0] second_mem [DEPTH];
   logic signed [31:0] first_rd_ff;
   logic signed [31:0] second_rd_ff;

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic [CW-1:0] first_idx_ff, first_idx_in;
   logic [CW-1:0] second_idx_ff, second_idx_in;
   logic [AW-1:0] first_addr, second_addr;

   logic              rsp_valid_ff, rsp_valid_in;
   ssum_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               first_ok, second_ok, take_first, take_second;
   logic signed [31:0] step_value;
   logic               step_last;
   logic               finish;

   always_comb begin
      first_ok    = first_idx_ff < first_count_ff;
      second_ok   = second_idx_ff < second_count_ff;
      take_first  = 1'b0;
      take_second = 1'b0;
      if (first_ok && second_ok) begin
         if (first_rd_ff < second_rd_ff) begin
            take_first = 1'b1;
         end else if (second_rd_ff < first_rd_ff) begin
            take_second = 1'b1;
         end else begin
            // Equal heads: emit once and advance both sides.
            take_first  = 1'b1;
            take_second = 1'b1;
         end
      end else if (second_ok) begin
         take_second = 1'b1;
      end else begin
         take_first = 1'b1;
      end
      step_value = take_first ? first_rd_ff : second_rd_ff;
   end

   always_comb begin
      first_idx_in  = first_idx_ff + CW'(take_first);
      second_idx_in = second_idx_ff + CW'(take_second);
      step_last = (first_idx_in >= first_count_ff) &&
                  (second_idx_in >= second_count_ff);
      finish = cmd.step && step_last;
      if (!cmd.step || finish) begin
         first_idx_in  = finish ? '0 : first_idx_ff;
         second_idx_in = finish ? '0 : second_idx_ff;
      end
   end

   assign status.step_last = step_last;

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (cmd.wr_first) begin
         first_count_in = first_count_ff + CW'(1);
      end
      if (cmd.wr_second) begin
         second_count_in = second_count_ff + CW'(1);
      end
      if (finish) begin
         first_count_in  = '0;
         second_count_in = '0;
      end
   end

   // The read address follows the next head index, so the registered read
   // data always holds the current head.
   assign first_addr  = (first_idx_in < FULL_COUNT) ? first_idx_in[AW-1:0] : '0;
   assign second_addr = (second_idx_in < FULL_COUNT) ? second_idx_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         first_mem[first_count_ff[AW-1:0]] <= load_value;
      end
      if (cmd.wr_second) begin
         second_mem[second_count_ff[AW-1:0]] <= load_value;
      end
      first_rd_ff  <= first_mem[first_addr];
      second_rd_ff <= second_mem[second_addr];
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.first_full  = first_count_ff == FULL_COUNT;
   assign status.second_full = second_count_ff == FULL_COUNT;
   assign status.both_empty  = (first_count_ff == '0) && (second_count_ff == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.out_free) begin
         rsp_valid_in = cmd.emit_drop || cmd.step;
         if (cmd.emit_drop) begin
            rsp_data_in.merged_value = '0;
            rsp_data_in.last         = 1'b0;
            rsp_data_in.dropped      = 1'b1;
         end else begin
            rsp_data_in.merged_value = step_value;
            rsp_data_in.last         = step_last;
            rsp_data_in.dropped      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_idx_ff    <= '0;
         second_idx_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_idx_ff    <= first_idx_in;
         second_idx_ff   <= second_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= FULL_COUNT) && (second_count_ff <= FULL_COUNT))
      else $error("store count beyond depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (first_idx_ff <= first_count_ff) && (second_idx_ff <= second_count_ff))
      else $error("head index beyond count");

   a_last_not_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.last && rsp_data_ff.dropped))
      else $error("result flagged both last and dropped");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish |=> (first_count_ff == '0) && (second_count_ff == '0))
      else $error("counts not cleared after merge run");

endmodule

// ----- design/sorted_set_union_merge.sv -----
`timescale 1ns / 1ps
// Timing: a dropped load shows its result in the cycle after acceptance.
// An accepted merge request enters ST_MERGE, then gives one result per cycle while the output
// is not stalled, from the registered heads of the two stores until the last one (none if both are empty).
// Throughput: one load per cycle while the output is not stalled; a merge holds the input until its last result.
// Reset (synchronous, active high) clears both counts, the walk and the output register.

module sorted_set_union_merge #(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ssum_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssum_pkg::rsp_type rsp_data
);

   ssum_pkg::cmd_type    cmd;
   ssum_pkg::status_type status;

   ssum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.kind),
      .status    (status),
      .cmd       (cmd)
   );

   ssum_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load_value (req_data.value),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
